FILE: hw/rtl/cfr_pkg.sv
`default_nettype none

package cfr_pkg;

  typedef logic [7:0] byte_t;

  localparam byte_t CRC_INIT      = 8'hFF;
  localparam byte_t CRC_POLY_REFL = 8'hE0;
  localparam byte_t PAD_BYTE      = 8'h00;
  localparam byte_t FLIP_MODE_ONE = 8'h01;
  localparam byte_t FLIP_MODE_TWO = 8'hC0;

  function automatic byte_t crc8_update(input byte_t crc, input byte_t data);
    byte_t c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cfr_msg_if.sv
`default_nettype none

interface cfr_msg_if;
  logic           valid;
  logic           ready;
  cfr_pkg::byte_t data_byte;
  logic           msg_last;

  modport source (output valid, output data_byte, output msg_last, input ready);
  modport sink   (input valid, input data_byte, input msg_last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/cfr_frame_if.sv
`default_nettype none

interface cfr_frame_if;
  logic           valid;
  logic           ready;
  cfr_pkg::byte_t out_byte;
  logic           is_check;
  logic           run_end;
  logic           msg_end;

  modport source (output valid, output out_byte, output is_check, output run_end,
                  output msg_end, input ready);
  modport sink   (input valid, input out_byte, input is_check, input run_end,
                  input msg_end, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/block_crc8_framer_with_fault_inject.sv
// Channel    | Dir | Payload                                  | Transaction
// msg        | in  | data_byte[7:0], msg_last                 | valid & ready
// frame      | out | out_byte[7:0], is_check, run_end, msg_end | valid & ready
// cfg        | in  | cfg_wr_data (fault_enable)               | cfg_wr_en
//
// One result leaves the result register per cycle while frame.ready is high; an item
// has 1 result mid block, 2 when it closes a block, up to BLOCK_BYTES + 1 at a
// message end. The item register is reloaded in the cycle its last result is issued.
// Synchronous reset clears both registers' valid bits, the block state and fault
// mode, and sets fault_enable. A stalled result holds in the result register.
`default_nettype none

module block_crc8_framer_with_fault_inject #(
  parameter int BLOCK_BYTES = 4
) (
  input  wire logic   clk,
  input  wire logic   rst,
  cfr_msg_if.sink     msg,
  cfr_frame_if.source frame,
  input  wire logic   cfg_wr_en,
  input  wire logic   cfg_wr_data
);

  localparam int POS_W = (BLOCK_BYTES > 2) ? $clog2(BLOCK_BYTES) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_BYTES - 1);
  localparam logic [POS_W-1:0] POS_ZERO = '0;
  localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1);

  localparam logic [1:0] PH_DATA = 2'd0;
  localparam logic [1:0] PH_PAD  = 2'd1;
  localparam logic [1:0] PH_CRC  = 2'd2;

  localparam logic [1:0] FM_OFF = 2'd0;
  localparam logic [1:0] FM_ONE = 2'd1;
  localparam logic [1:0] FM_TWO = 2'd2;

  logic fault_enable;

  logic           item_valid;
  cfr_pkg::byte_t item_byte;
  logic           item_last;
  logic [1:0]     phase;
  logic [1:0]     phase_next;

  cfr_pkg::byte_t   running_crc;
  cfr_pkg::byte_t   running_crc_next;
  logic [POS_W-1:0] block_pos;
  logic [POS_W-1:0] block_pos_next;
  logic             in_first_block;
  logic             in_first_block_next;
  logic [1:0]       fault_mode;
  logic [1:0]       fault_mode_next;

  logic           out_valid;
  cfr_pkg::byte_t out_byte;
  logic           is_check;
  logic           run_end;
  logic           msg_end;

  logic           emit;
  logic           done;
  logic           accept;
  cfr_pkg::byte_t src_byte;
  cfr_pkg::byte_t sent_byte;
  cfr_pkg::byte_t flip_mask;
  logic           res_check;

  assign emit   = item_valid && (!out_valid || frame.ready);
  assign accept = msg.valid && msg.ready;
  assign msg.ready = !item_valid || (emit && done);

  assign src_byte = (phase == PH_DATA) ? item_byte : cfr_pkg::PAD_BYTE;

  always_comb begin
    flip_mask = '0;
    if (fault_enable && in_first_block) begin
      if (fault_mode == FM_ONE && block_pos == POS_ZERO) begin
        flip_mask = cfr_pkg::FLIP_MODE_ONE;
      end else if (fault_mode == FM_TWO && block_pos == POS_ONE) begin
        flip_mask = cfr_pkg::FLIP_MODE_TWO;
      end
    end
  end

  always_comb begin
    phase_next          = phase;
    done                = 1'b0;
    res_check           = 1'b0;
    sent_byte           = src_byte ^ flip_mask;
    running_crc_next    = cfr_pkg::crc8_update(running_crc, src_byte);
    block_pos_next      = block_pos + POS_ONE;
    in_first_block_next = in_first_block;
    fault_mode_next     = fault_mode;
    unique case (phase)
      PH_DATA: begin
        if (block_pos == POS_LAST) begin
          phase_next = PH_CRC;
        end else if (item_last) begin
          phase_next = PH_PAD;
        end else begin
          done = 1'b1;
        end
      end
      PH_PAD: begin
        if (block_pos == POS_LAST) begin
          phase_next = PH_CRC;
        end
      end
      PH_CRC: begin
        done                = 1'b1;
        res_check           = 1'b1;
        sent_byte           = running_crc;
        running_crc_next    = cfr_pkg::CRC_INIT;
        block_pos_next      = POS_ZERO;
        in_first_block_next = 1'b0;
        phase_next          = PH_DATA;
        if (item_last) begin
          in_first_block_next = 1'b1;
          unique case (fault_mode)
            FM_OFF:  fault_mode_next = FM_ONE;
            FM_ONE:  fault_mode_next = FM_TWO;
            default: fault_mode_next = FM_OFF;
          endcase
        end
      end
      default: begin
        done       = 1'b1;
        phase_next = PH_DATA;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_enable <= 1'b1;
    end else if (cfg_wr_en) begin
      fault_enable <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid     <= 1'b0;
      phase          <= PH_DATA;
      running_crc    <= cfr_pkg::CRC_INIT;
      block_pos      <= POS_ZERO;
      in_first_block <= 1'b1;
      fault_mode     <= FM_OFF;
    end else begin
      if (emit) begin
        running_crc    <= running_crc_next;
        block_pos      <= block_pos_next;
        in_first_block <= in_first_block_next;
        fault_mode     <= fault_mode_next;
        phase          <= phase_next;
      end
      if (accept) begin
        item_valid <= 1'b1;
      end else if (emit && done) begin
        item_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_byte <= msg.data_byte;
      item_last <= msg.msg_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (frame.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= sent_byte;
      is_check <= res_check;
      run_end  <= done;
      msg_end  <= done && item_last;
    end
  end

  assign frame.valid    = out_valid;
  assign frame.out_byte = out_byte;
  assign frame.is_check = is_check;
  assign frame.run_end  = run_end;
  assign frame.msg_end  = msg_end;

  a_msg_end_on_check: assert property (@(posedge clk) disable iff (rst)
    frame.valid && frame.msg_end |-> frame.is_check && frame.run_end)
    else $error("msg_end on a result that is not a closing CRC");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    item_valid && !(emit && done) |-> !msg.ready)
    else $error("input taken while the held item still has results");

  a_msg_end_resets_block: assert property (@(posedge clk) disable iff (rst)
    emit && phase == PH_CRC && item_last |=>
      block_pos == POS_ZERO && in_first_block && running_crc == cfr_pkg::CRC_INIT)
    else $error("block state not restored after message end");

  a_pad_only_at_end: assert property (@(posedge clk) disable iff (rst)
    item_valid && phase == PH_PAD |-> item_last)
    else $error("padding outside a message end");

  a_stalled_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame.ready |=> out_valid && $stable(out_byte) && $stable(run_end))
    else $error("stalled result changed");

endmodule

`default_nettype wire
